[design/rms_norm_row_weighted_unit_assert.svh]
// assertion macros for the rms normalization unit and its port checker
// no dependencies; included by the checker file
`ifndef RMS_NORM_ROW_WEIGHTED_UNIT_ASSERT_SVH
`define RMS_NORM_ROW_WEIGHTED_UNIT_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define RMSN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RMSN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/rmsn_pkg.sv]
// shared constants and types for the rms normalization unit
// no dependencies; used by rmsn_seq_unit, rmsn_scale and the top level
package rmsn_pkg;

	localparam int DATA_BITS = 16;
	localparam int MAX_WIDTH = 64;
	localparam int IDX_BITS  = 6;
	localparam int CNT_BITS  = 7;
	localparam int ACC_BITS  = 37;
	localparam int EPS_BITS  = 30;
	localparam int WOFF_BITS = 16;
	localparam int INV_BITS  = 31;
	localparam int NUM_BITS  = 62;
	localparam int DEN_BITS  = 38;
	localparam int REM_BITS  = 40;
	localparam int ITER_BITS = 6;

	// configuration register indexes
	localparam logic REG_EPS  = 1'b0;
	localparam logic REG_WOFF = 1'b1;

	// iteration counts of the shared unit
	localparam logic [ITER_BITS-1:0] ITER_MEAN  = 6'd37;
	localparam logic [ITER_BITS-1:0] ITER_RECIP = 6'd62;
	localparam logic [ITER_BITS-1:0] ITER_ROOT  = 6'd31;

	typedef enum logic {
		MODE_DIV  = 1'b0,
		MODE_SQRT = 1'b1
	} seq_mode_t;

	typedef struct packed {
		logic                 start;
		seq_mode_t            mode;
		logic [ITER_BITS-1:0] iters;
	} seq_cmd_t;

endpackage

[design/rmsn_seq_unit.sv]
// shared shift-compare-subtract unit: restoring division or digit square root
// depends on rmsn_pkg
module rmsn_seq_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmsn_pkg::seq_cmd_t            cmd,
	input  logic [rmsn_pkg::NUM_BITS-1:0] num_init,
	input  logic [rmsn_pkg::DEN_BITS-1:0] den,
	output logic                          busy,
	output logic [rmsn_pkg::NUM_BITS-1:0] result
);

	logic [rmsn_pkg::REM_BITS-1:0]  rem_q;
	logic [rmsn_pkg::NUM_BITS-1:0]  num_q;
	logic [rmsn_pkg::NUM_BITS-1:0]  quo_q;
	logic [rmsn_pkg::DEN_BITS-1:0]  den_q;
	logic [rmsn_pkg::ITER_BITS-1:0] cnt_q;
	rmsn_pkg::seq_mode_t            mode_q;
	logic                           busy_q;
	logic [rmsn_pkg::REM_BITS-1:0]  cand;
	logic [rmsn_pkg::REM_BITS-1:0]  trial;
	logic [rmsn_pkg::REM_BITS-1:0]  diff;
	logic                           ge;

	// candidate remainder and trial subtrahend for one step
	always_comb begin
		unique case (mode_q)
			rmsn_pkg::MODE_DIV: begin
				cand  = {rem_q[rmsn_pkg::REM_BITS-2:0], num_q[rmsn_pkg::NUM_BITS-1]};
				trial = {2'b00, den_q};
			end
			rmsn_pkg::MODE_SQRT: begin
				cand  = {rem_q[rmsn_pkg::REM_BITS-3:0],
					num_q[rmsn_pkg::NUM_BITS-1:rmsn_pkg::NUM_BITS-2]};
				trial = {quo_q[rmsn_pkg::REM_BITS-3:0], 2'b01};
			end
			default: begin
				cand  = '0;
				trial = '0;
			end
		endcase
		ge   = (cand >= trial);
		diff = cand - trial;
	end

	// payload registers of the iteration
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= '0;
			num_q  <= num_init;
			quo_q  <= '0;
			den_q  <= den;
			mode_q <= cmd.mode;
		end else if (busy_q) begin
			rem_q <= ge ? diff : cand;
			quo_q <= {quo_q[rmsn_pkg::NUM_BITS-2:0], ge};
			if (mode_q == rmsn_pkg::MODE_DIV) begin
				num_q <= {num_q[rmsn_pkg::NUM_BITS-2:0], 1'b0};
			end else begin
				num_q <= {num_q[rmsn_pkg::NUM_BITS-3:0], 2'b00};
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy   = busy_q;
	assign result = quo_q;

endmodule

[design/rmsn_scale.sv]
// two-stage multiply, round and saturate for one output element
// depends on rmsn_pkg
module rmsn_scale (
	input  logic                           clk,
	input  logic [rmsn_pkg::DATA_BITS-1:0] x_value,
	input  logic [rmsn_pkg::DATA_BITS-1:0] weight_value,
	input  logic [rmsn_pkg::WOFF_BITS-1:0] gain_bias,
	input  logic [rmsn_pkg::INV_BITS-1:0]  inv,
	output logic [rmsn_pkg::DATA_BITS-1:0] y_value,
	output logic                           sat
);

	logic signed [16:0] wo;
	logic [15:0]        mag_x;
	logic [16:0]        mag_wo;
	logic [31:0]        a_s1;
	logic               neg_s1;
	logic [62:0]        p_s2;
	logic               neg_s2;
	logic [63:0]        rsum;
	logic [32:0]        r;

	// offset weight and magnitudes
	always_comb begin
		wo     = $signed({weight_value[15], weight_value})
			+ $signed({gain_bias[15], gain_bias});
		mag_x  = x_value[15] ? 16'(-x_value) : x_value;
		mag_wo = wo[16] ? 17'(-wo) : 17'(wo);
	end

	// stage 1: magnitude product, stage 2: times inverse root
	always_ff @(posedge clk) begin
		a_s1   <= 32'({16'b0, mag_x} * {15'b0, mag_wo});
		neg_s1 <= x_value[15] ^ wo[16];
		p_s2   <= 63'({31'b0, a_s1} * {32'b0, inv});
		neg_s2 <= neg_s1;
	end

	// round half away from zero, then saturate
	always_comb begin
		rsum = {1'b0, p_s2} + 64'd536870912;
		r    = rsum[62:30];
		if (!neg_s2) begin
			sat     = (r > 33'd32767);
			y_value = sat ? 16'h7fff : r[15:0];
		end else begin
			sat     = (r > 33'd32768);
			y_value = sat ? 16'h8000 : 16'(-r[15:0]);
		end
	end

endmodule

[design/rms_norm_row_weighted_unit.sv]
// rms normalization of one weighted row: top level with sequencer and row memory
// depends on rmsn_pkg, rmsn_seq_unit, rmsn_scale
//
// channel   dir  handshake        payload
// s_*       in   tvalid/tready    tdata {weight_value, x_value}, tlast row_end
// m_*       out  tvalid/tready    tdata {pad, column_index, y_value}, tlast run_last,
//                                 tuser overflow_flag
// cfg_*     in   cfg_we           cfg_index 0 eps, 1 weight bias
//
// an element is stored as it is taken; the row end then runs the shared divide/root
// unit for 37 mean, 62 reciprocal and 31 root steps, each run started from a load
// state, then each element passes through memory read and the
// two multiply stages.
// the block takes no input while a row is being computed or emitted.
// reset clears the sequencer and counters, sets eps to 168 and the weight bias to zero; the row memory is not cleared.
// output stalls hold the result register and pause the emission.
module rms_norm_row_weighted_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_value[15:0], weight_value[31:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // y_value[15:0], column_index[21:16], zero[23:22]
	output logic        m_tlast,
	output logic        m_tuser,   // overflow_flag[0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [29:0] cfg_data
);

	typedef enum logic [11:0] {
		ST_ACC      = 12'b000000000001,
		ST_LD_MEAN  = 12'b000000000010,
		ST_WT_MEAN  = 12'b000000000100,
		ST_LD_RECIP = 12'b000000001000,
		ST_WT_RECIP = 12'b000000010000,
		ST_LD_ROOT  = 12'b000000100000,
		ST_WT_ROOT  = 12'b000001000000,
		ST_RD       = 12'b000010000000,
		ST_MUL1     = 12'b000100000000,
		ST_MUL2     = 12'b001000000000,
		ST_RND      = 12'b010000000000,
		ST_OUT      = 12'b100000000000
	} state_t;

	state_t                          state_q;
	logic [rmsn_pkg::CNT_BITS-1:0]   count_q;
	logic [rmsn_pkg::ACC_BITS-1:0]   acc_q;
	logic                            ovf_q;
	logic [rmsn_pkg::IDX_BITS-1:0]   k_q;
	logic [rmsn_pkg::EPS_BITS-1:0]   eps_q;
	logic [rmsn_pkg::WOFF_BITS-1:0]  woff_q;
	logic [rmsn_pkg::INV_BITS-1:0]   inv_q;
	logic [31:0]                     row_mem [rmsn_pkg::MAX_WIDTH];
	logic [31:0]                     rd_q;
	logic [15:0]                     y_q;
	logic [rmsn_pkg::IDX_BITS-1:0]   col_q;
	logic                            last_q;
	logic                            flag_q;
	logic                            s_xfer;
	logic                            store;
	logic signed [31:0]              sq;
	rmsn_pkg::seq_cmd_t              cmd;
	logic [rmsn_pkg::NUM_BITS-1:0]   num_init;
	logic [rmsn_pkg::DEN_BITS-1:0]   den;
	logic [rmsn_pkg::DEN_BITS-1:0]   msq;
	logic                            busy;
	logic [rmsn_pkg::NUM_BITS-1:0]   result;
	logic [15:0]                     y_new;
	logic                            sat;
	logic                            is_last;

	assign s_tready = (state_q == ST_ACC);
	assign s_xfer   = s_tvalid && s_tready;
	assign store    = s_xfer && (count_q < rmsn_pkg::CNT_BITS'(rmsn_pkg::MAX_WIDTH));
	assign sq       = $signed(s_tdata[15:0]) * $signed(s_tdata[15:0]);
	assign is_last  = ({1'b0, k_q} + 1'b1) == count_q;

	// mean square plus eps, at least one unit
	always_comb begin
		msq = result[rmsn_pkg::DEN_BITS-1:0] + {8'b0, eps_q};
		if (msq == '0) begin
			msq = rmsn_pkg::DEN_BITS'(1);
		end
	end

	// commands for the shared unit
	always_comb begin
		cmd      = '0;
		num_init = '0;
		den      = '0;
		unique case (state_q)
			ST_LD_MEAN: begin
				cmd      = '{start: 1'b1, mode: rmsn_pkg::MODE_DIV, iters: rmsn_pkg::ITER_MEAN};
				num_init = {acc_q, 25'b0};
				den      = {31'b0, count_q};
			end
			ST_LD_RECIP: begin
				cmd      = '{start: 1'b1, mode: rmsn_pkg::MODE_DIV, iters: rmsn_pkg::ITER_RECIP};
				num_init = rmsn_pkg::NUM_BITS'(1) << 60;
				den      = msq;
			end
			ST_LD_ROOT: begin
				cmd      = '{start: 1'b1, mode: rmsn_pkg::MODE_SQRT, iters: rmsn_pkg::ITER_ROOT};
				num_init = result;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	rmsn_seq_unit u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.num_init (num_init),
		.den      (den),
		.busy     (busy),
		.result   (result)
	);

	rmsn_scale u_scale (
		.clk          (clk),
		.x_value      (rd_q[15:0]),
		.weight_value (rd_q[31:16]),
		.gain_bias    (woff_q),
		.inv          (inv_q),
		.y_value      (y_new),
		.sat          (sat)
	);

	// row memory: one write while storing, one registered read while emitting
	always_ff @(posedge clk) begin
		if (store) begin
			row_mem[count_q[rmsn_pkg::IDX_BITS-1:0]] <= s_tdata;
		end
		rd_q <= row_mem[k_q];
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_RND) begin
			y_q    <= y_new;
			col_q  <= k_q;
			last_q <= is_last;
			flag_q <= ovf_q || sat;
		end
		if (state_q == ST_WT_ROOT && !busy) begin
			inv_q <= result[rmsn_pkg::INV_BITS-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= 30'd168;
			woff_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmsn_pkg::REG_EPS:  eps_q  <= cfg_data;
				rmsn_pkg::REG_WOFF: woff_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			count_q <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (s_xfer) begin
						if (store) begin
							acc_q   <= acc_q + {6'b0, sq[30:0]};
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_LD_MEAN;
						end
					end
				end
				ST_LD_MEAN:  state_q <= ST_WT_MEAN;
				ST_WT_MEAN:  if (!busy) state_q <= ST_LD_RECIP;
				ST_LD_RECIP: state_q <= ST_WT_RECIP;
				ST_WT_RECIP: if (!busy) state_q <= ST_LD_ROOT;
				ST_LD_ROOT:  state_q <= ST_WT_ROOT;
				ST_WT_ROOT: begin
					if (!busy) begin
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:   state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_RND;
				ST_RND:  state_q <= ST_OUT;
				ST_OUT: begin
					if (m_tready) begin
						if (last_q) begin
							count_q <= '0;
							acc_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_ACC;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {2'b00, col_q, y_q};
	assign m_tlast  = last_q;
	assign m_tuser  = flag_q;

endmodule

[design/rmsn_checker.sv]
// port-level checker for the rms normalization unit, bound to the top level
// depends on rms_norm_row_weighted_unit_assert.svh
`include "rms_norm_row_weighted_unit_assert.svh"

module rmsn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// input and output never open in the same cycle
	`RMSN_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input ready while result pending")

	// a stalled result holds its payload
	`RMSN_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held result changed")

	// after the last transfer of a row the block takes input again
	`RMSN_ASSERT(a_reopen, m_tvalid && m_tready && m_tlast |=> s_tready, "not ready after row end")

	// padding bits stay zero
	`RMSN_ASSERT_ALWAYS(a_pad, !m_tvalid || m_tdata[23:22] == 2'b00, "padding bits set")

endmodule

bind rms_norm_row_weighted_unit rmsn_checker u_rmsn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
